/* src/uat_pkg.sv */
// Shared constants, codes and types for the unsorted array table.
package uat_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic match_en;
    logic insert_en;
    logic delete_en;
  } cell_ctrl_t;

endpackage

/* src/uat_cell.sv */
// One table cell: holds an entry, compares it with the key and shifts down on delete.
module uat_cell
  import uat_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IDX_W-1:0]        cell_idx,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] key,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [VAL_W-1:0] up_value,
  input  logic                    hit_in,
  output logic                    hit_out,
  output logic                    first,
  output logic signed [VAL_W-1:0] value_out
);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    match_r;
  logic                    match_nxt;
  logic                    in_use;

  assign in_use = ({1'b0, cell_idx} < {1'b0, count});

  always_comb begin
    match_nxt = match_r;
    if (ctrl.match_en) begin
      match_nxt = in_use && (value_r == key);
    end
  end

  always_comb begin
    value_nxt = value_r;
    if (ctrl.insert_en && (CNT_W'(cell_idx) == count)) begin
      value_nxt = key;
    end else if (ctrl.delete_en && (hit_in || match_r)) begin
      value_nxt = up_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign hit_out   = hit_in || match_r;
  assign first     = match_r && !hit_in;
  assign value_out = value_r;

endmodule

/* src/unsorted_array_table_unit.sv */
// Top level of the unsorted array table: command sequencer, count and result register.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_stall, in_cmd, in_value     | in
//   result  | out_valid, out_stall, out_status,        | out
//           | out_index, out_entry_count               |
//
// Each command passes the idle state, in which it is accepted, a compare state in
// which every cell compares its entry with the key, and a resolve state in which the
// first-match chain resolves, the table is updated and the result beat is registered.
// A new command is taken once the previous one has left the sequencer, even while
// its result beat is still stalled. A stalled result holds the sequencer in its
// resolve state. Reset empties the table; entry contents are not cleared.
module unsorted_array_table_unit
  import uat_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [3:0]              out_index,
  output logic [4:0]              out_entry_count
);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_MATCH   = 3'b010,
    S_RESOLVE = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              cmd_r, cmd_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [3:0]              index_r, index_nxt;
  logic [4:0]              ecount_r, ecount_nxt;

  logic                    accept;
  logic                    go;
  logic                    found;
  logic                    full;
  logic [IDX_W-1:0]        found_idx;
  cell_ctrl_t              ctrl;

  logic [CAPACITY:0]       hit;
  logic [CAPACITY-1:0]     first;
  logic signed [VAL_W-1:0] cell_value [CAPACITY];

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign go = (state_r == S_RESOLVE) && (!out_valid_r || !out_stall);
  assign full = (count_r >= CNT_W'(CAPACITY));

  assign ctrl.match_en  = (state_r == S_MATCH);
  assign ctrl.insert_en = go && (cmd_r == CMD_INSERT) && !full;
  assign ctrl.delete_en = go && (cmd_r == CMD_DELETE) && found;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    uat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .ctrl      (ctrl),
      .key       (key_r),
      .count     (count_r),
      .up_value  ((i == CAPACITY - 1) ? cell_value[i] : cell_value[(i + 1) % CAPACITY]),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .first     (first[i]),
      .value_out (cell_value[i])
    );
  end

  assign found = hit[CAPACITY];

  always_comb begin
    found_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        found_idx = found_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    if (accept) begin
      cmd_nxt = in_cmd;
      key_nxt = in_value;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    index_nxt     = index_r;
    ecount_nxt    = ecount_r;
    if (go) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_NOT_FOUND;
      index_nxt     = '0;
      unique case (cmd_r)
        CMD_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_OK;
            index_nxt  = 4'(count_r);
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        CMD_SEARCH: begin
          if (found) begin
            status_nxt = ST_OK;
            index_nxt  = 4'(found_idx);
          end
        end
        CMD_DELETE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (found) begin
            status_nxt = ST_OK;
            index_nxt  = 4'(found_idx);
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = ST_NOT_FOUND;
        end
      endcase
      ecount_nxt = 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
    ecount_r <= ecount_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_index       = index_r;
  assign out_entry_count = ecount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MATCH))
    else $error("accepted command did not enter the compare cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESOLVE))
    else $error("result beat appeared outside the resolve cycle");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == ST_OK || index_r == 4'd0))
    else $error("nonzero index on a failed command");

  a_single_first: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first))
    else $error("more than one first match in the chain");

endmodule
